/* rtl/sobb_pkg.sv */
package sobb_pkg;

    localparam int COORD_BITS_DEF    = 21;
    localparam int ROT_FRAC_BITS_DEF = 14;
    localparam int ROT_ENTRY_W       = 16;
    localparam int AXES              = 3;
    localparam int ROT_ROW_W         = AXES * ROT_ENTRY_W;
    localparam int RADIUS_W          = 21;
    localparam int QUEUE_DEPTH       = 4;
    localparam int BACK_STAGES       = 7;

    typedef struct packed {
        logic full;
        logic empty;
    } sobb_qstat_t;

endpackage

/* rtl/sobb_ifs.sv */
interface sobb_query_if #(
    parameter int COORD_BITS = sobb_pkg::COORD_BITS_DEF
) ();
    import sobb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [AXES*COORD_BITS-1:0]    sphere_center;
    logic signed [RADIUS_W-1:0]    sphere_radius;
    logic [AXES*COORD_BITS-1:0]    box_center;
    logic [AXES*COORD_BITS-1:0]    box_size;
    logic [ROT_ROW_W-1:0]          rot_row0;
    logic [ROT_ROW_W-1:0]          rot_row1;
    logic [ROT_ROW_W-1:0]          rot_row2;

    modport source (
        output valid, sphere_center, sphere_radius, box_center, box_size,
               rot_row0, rot_row1, rot_row2,
        input  ready
    );
    modport sink (
        input  valid, sphere_center, sphere_radius, box_center, box_size,
               rot_row0, rot_row1, rot_row2,
        output ready
    );
endinterface

interface sobb_result_if ();
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );
    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

/* rtl/sphere_obb_overlap_test.sv */
// Channel   Role     Word
// query     sink     sphere centre and radius, box centre, size and rotation rows
// result    source   hit flag, one word per query word, in order
//
// One query word is taken every cycle while the queue has room; its result word
// passes one front register, one queue slot and seven back stages before it is
// valid on the result channel.
// A stalled result holds the back pipeline; the four-word queue then fills
// and the front holds its word until the queue frees a slot.
// Reset clears the valid flags and the queue pointers; no clearing pass.
module sphere_obb_overlap_test #(
    parameter int COORD_BITS    = sobb_pkg::COORD_BITS_DEF,
    parameter int ROT_FRAC_BITS = sobb_pkg::ROT_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    sobb_query_if.sink      query,
    sobb_result_if.source   result
);
    import sobb_pkg::*;

    localparam int D_W = COORD_BITS + 1;
    localparam int H_W = COORD_BITS + ROT_FRAC_BITS - 2;
    localparam int Q_W = AXES*D_W + AXES*ROT_ROW_W + AXES*H_W + RADIUS_W;

    sobb_qstat_t                qstat;
    logic                       f_valid;
    logic [AXES*D_W-1:0]        f_d;
    logic [AXES*ROT_ROW_W-1:0]  f_rot;
    logic [AXES*H_W-1:0]        f_hext;
    logic [RADIUS_W-2:0]        f_rad_mag;
    logic                       f_rad_neg;
    logic                       q_push;
    logic                       q_pop;
    logic [Q_W-1:0]             q_wdata;
    logic [Q_W-1:0]             q_rdata;
    logic                       b_ready;
    logic [AXES*D_W-1:0]        b_d;
    logic [AXES*ROT_ROW_W-1:0]  b_rot;
    logic [AXES*H_W-1:0]        b_hext;
    logic [RADIUS_W-2:0]        b_rad_mag;
    logic                       b_rad_neg;

    sobb_front #(
        .COORD_BITS    (COORD_BITS),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query),
        .qstat   (qstat),
        .valid   (f_valid),
        .d       (f_d),
        .rot     (f_rot),
        .hext    (f_hext),
        .rad_mag (f_rad_mag),
        .rad_neg (f_rad_neg)
    );

    assign q_push  = f_valid && !qstat.full;
    assign q_pop   = !qstat.empty && b_ready;
    assign q_wdata = {f_rad_neg, f_rad_mag, f_hext, f_rot, f_d};
    assign {b_rad_neg, b_rad_mag, b_hext, b_rot, b_d} = q_rdata;

    sobb_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (qstat)
    );

    sobb_back #(
        .COORD_BITS    (COORD_BITS),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (!qstat.empty),
        .ready   (b_ready),
        .d       (b_d),
        .rot     (b_rot),
        .hext    (b_hext),
        .rad_mag (b_rad_mag),
        .rad_neg (b_rad_neg),
        .result  (result)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && qstat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && qstat.empty))
        else $error("queue read while empty");

    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && qstat.full) |=> (f_valid && $stable(f_d) && $stable(f_rad_neg)))
        else $error("front word lost while queue full");
`endif

endmodule

/* rtl/sobb_front.sv */
module sobb_front #(
    parameter int COORD_BITS    = sobb_pkg::COORD_BITS_DEF,
    parameter int ROT_FRAC_BITS = sobb_pkg::ROT_FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    sobb_query_if.sink                                  query,
    input  sobb_pkg::sobb_qstat_t                       qstat,
    output logic                                        valid,
    output logic [sobb_pkg::AXES*(COORD_BITS+1)-1:0]    d,
    output logic [sobb_pkg::AXES*sobb_pkg::ROT_ROW_W-1:0] rot,
    output logic [sobb_pkg::AXES*(COORD_BITS+ROT_FRAC_BITS-2)-1:0] hext,
    output logic [sobb_pkg::RADIUS_W-2:0]               rad_mag,
    output logic                                        rad_neg
);
    import sobb_pkg::*;

    localparam int D_W = COORD_BITS + 1;
    localparam int H_W = COORD_BITS + ROT_FRAC_BITS - 2;

    logic                       valid_reg;
    logic                       valid_next;
    logic [AXES*D_W-1:0]        d_reg;
    logic [AXES*D_W-1:0]        d_next;
    logic [AXES*ROT_ROW_W-1:0]  rot_reg;
    logic [AXES*ROT_ROW_W-1:0]  rot_next;
    logic [AXES*H_W-1:0]        hext_reg;
    logic [AXES*H_W-1:0]        hext_next;
    logic [RADIUS_W-2:0]        rad_mag_reg;
    logic [RADIUS_W-2:0]        rad_mag_next;
    logic                       rad_neg_reg;
    logic                       rad_neg_next;
    logic                       take;

    // The held word leaves for the queue in any cycle the queue has room.
    assign query.ready = !valid_reg || !qstat.full;
    assign take        = query.valid && query.ready;

    always_comb
    begin
        valid_next = take || (valid_reg && qstat.full);
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            logic signed [COORD_BITS-1:0] sc;
            logic signed [COORD_BITS-1:0] bc;
            logic signed [COORD_BITS-1:0] sz;
            sc = query.sphere_center[i*COORD_BITS +: COORD_BITS];
            bc = query.box_center[i*COORD_BITS +: COORD_BITS];
            sz = query.box_size[i*COORD_BITS +: COORD_BITS];
            d_next[i*D_W +: D_W] = D_W'(sc) - D_W'(bc);
            // Half extent at the product scale; a negative extent flattens the axis.
            if (sz[COORD_BITS-1])
            begin
                hext_next[i*H_W +: H_W] = '0;
            end
            else
            begin
                hext_next[i*H_W +: H_W] = {sz[COORD_BITS-2:0], {(ROT_FRAC_BITS-1){1'b0}}};
            end
        end
        rot_next     = {query.rot_row2, query.rot_row1, query.rot_row0};
        rad_mag_next = query.sphere_radius[RADIUS_W-2:0];
        rad_neg_next = query.sphere_radius[RADIUS_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            d_reg       <= d_next;
            rot_reg     <= rot_next;
            hext_reg    <= hext_next;
            rad_mag_reg <= rad_mag_next;
            rad_neg_reg <= rad_neg_next;
        end
    end

    assign valid   = valid_reg;
    assign d       = d_reg;
    assign rot     = rot_reg;
    assign hext    = hext_reg;
    assign rad_mag = rad_mag_reg;
    assign rad_neg = rad_neg_reg;

endmodule

/* rtl/sobb_queue.sv */
module sobb_queue #(
    parameter int W     = 1,
    parameter int DEPTH = sobb_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [W-1:0]            wdata,
    input  logic                    pop,
    output logic [W-1:0]            rdata,
    output sobb_pkg::sobb_qstat_t   stat
);
    import sobb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]       mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* rtl/sobb_back.sv */
module sobb_back #(
    parameter int COORD_BITS    = sobb_pkg::COORD_BITS_DEF,
    parameter int ROT_FRAC_BITS = sobb_pkg::ROT_FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        valid,
    output logic                                        ready,
    input  logic [sobb_pkg::AXES*(COORD_BITS+1)-1:0]    d,
    input  logic [sobb_pkg::AXES*sobb_pkg::ROT_ROW_W-1:0] rot,
    input  logic [sobb_pkg::AXES*(COORD_BITS+ROT_FRAC_BITS-2)-1:0] hext,
    input  logic [sobb_pkg::RADIUS_W-2:0]               rad_mag,
    input  logic                                        rad_neg,
    sobb_result_if.source                               result
);
    import sobb_pkg::*;

    localparam int D_W    = COORD_BITS + 1;
    localparam int H_W    = COORD_BITS + ROT_FRAC_BITS - 2;
    localparam int PROD_W = D_W + ROT_ENTRY_W;
    localparam int P_W    = PROD_W + 2;
    localparam int MAG_W  = P_W - 1;
    localparam int EL_W   = MAG_W / 2;
    localparam int EH_W   = MAG_W - EL_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RM_W   = RADIUS_W - 1;
    localparam int RSQ_W  = 2 * RM_W;
    localparam int RL_W   = RSQ_W + 2 * ROT_FRAC_BITS;
    localparam int CMP_W  = (SUM_W > RL_W) ? SUM_W : RL_W;
    localparam int LAST   = BACK_STAGES - 1;

    logic                           adv;
    logic [BACK_STAGES-1:0]         vld_reg;
    logic [BACK_STAGES-1:0]         vld_next;
    logic [BACK_STAGES-2:0]         neg_reg;
    logic [BACK_STAGES-2:0]         neg_next;

    logic signed [D_W-1:0]          d_in   [AXES];
    logic signed [ROT_ENTRY_W-1:0]  rot_in [AXES][AXES];

    // Stage 1: the nine products of offset and rotation entries.
    logic signed [PROD_W-1:0]       m_reg  [AXES][AXES];
    logic signed [PROD_W-1:0]       m_next [AXES][AXES];
    logic [AXES*H_W-1:0]            h1_reg;
    logic [RM_W-1:0]                rad1_reg;
    // Stage 2: local coordinates and the squared radius.
    logic signed [P_W-1:0]          p_reg  [AXES];
    logic signed [P_W-1:0]          p_next [AXES];
    logic [AXES*H_W-1:0]            h2_reg;
    logic [RSQ_W-1:0]               rsq2_reg;
    logic [RSQ_W-1:0]               rsq2_next;
    // Stage 3: distance outside the box on each axis.
    logic [MAG_W-1:0]               e_reg  [AXES];
    logic [MAG_W-1:0]               e_next [AXES];
    logic [RSQ_W-1:0]               rsq3_reg;
    // Stage 4: partial products of each square.
    logic [2*EH_W-1:0]              hh_reg  [AXES];
    logic [2*EH_W-1:0]              hh_next [AXES];
    logic [EH_W+EL_W-1:0]           hl_reg  [AXES];
    logic [EH_W+EL_W-1:0]           hl_next [AXES];
    logic [2*EL_W-1:0]              ll_reg  [AXES];
    logic [2*EL_W-1:0]              ll_next [AXES];
    logic [RSQ_W-1:0]               rsq4_reg;
    // Stage 5: squares per axis.
    logic [SQ_W-1:0]                sq_reg  [AXES];
    logic [SQ_W-1:0]                sq_next [AXES];
    logic [RSQ_W-1:0]               rsq5_reg;
    // Stage 6: squared distance and the limit at the same scale.
    logic [CMP_W-1:0]               sum_reg;
    logic [CMP_W-1:0]               sum_next;
    logic [CMP_W-1:0]               rlim_reg;
    logic [CMP_W-1:0]               rlim_next;
    // Stage 7: the result word.
    logic                           hit_reg;
    logic                           hit_next;

    // The whole pipeline moves as one unless a finished word is held.
    assign adv   = !vld_reg[LAST] || result.ready;
    assign ready = adv;

    always_comb
    begin
        vld_next = vld_reg;
        neg_next = neg_reg;
        if (adv)
        begin
            vld_next = {vld_reg[BACK_STAGES-2:0], valid};
            neg_next = {neg_reg[BACK_STAGES-3:0], rad_neg};
        end
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            d_in[i] = d[i*D_W +: D_W];
            for (int k = 0; k < AXES; k++)
            begin
                rot_in[i][k] = rot[i*ROT_ROW_W + k*ROT_ENTRY_W +: ROT_ENTRY_W];
            end
        end
        for (int j = 0; j < AXES; j++)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                m_next[j][i] = PROD_W'(d_in[i]) * PROD_W'(rot_in[j][i]);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            p_next[j] = P_W'(m_reg[j][0]) + P_W'(m_reg[j][1]) + P_W'(m_reg[j][2]);
        end
        rsq2_next = RSQ_W'(rad1_reg) * RSQ_W'(rad1_reg);
    end

    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            logic [MAG_W-1:0] mag;
            logic [MAG_W-1:0] hz;
            mag = p_reg[j][P_W-1] ? MAG_W'(-p_reg[j]) : MAG_W'(p_reg[j]);
            hz  = MAG_W'(h2_reg[j*H_W +: H_W]);
            e_next[j] = (mag > hz) ? mag - hz : '0;
        end
    end

    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            logic [EH_W-1:0] eh;
            logic [EL_W-1:0] el;
            eh = e_reg[j][MAG_W-1:EL_W];
            el = e_reg[j][EL_W-1:0];
            hh_next[j] = (2*EH_W)'(eh) * (2*EH_W)'(eh);
            hl_next[j] = (EH_W+EL_W)'(eh) * (EH_W+EL_W)'(el);
            ll_next[j] = (2*EL_W)'(el) * (2*EL_W)'(el);
        end
    end

    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            sq_next[j] = (SQ_W'(hh_reg[j]) << (2*EL_W))
                       + (SQ_W'(hl_reg[j]) << (EL_W+1))
                       + SQ_W'(ll_reg[j]);
        end
    end

    always_comb
    begin
        sum_next  = CMP_W'(sq_reg[0]) + CMP_W'(sq_reg[1]) + CMP_W'(sq_reg[2]);
        rlim_next = CMP_W'(rsq5_reg) << (2*ROT_FRAC_BITS);
    end

    always_comb
    begin
        hit_next = !neg_reg[BACK_STAGES-2] && (sum_reg <= rlim_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        if (adv)
        begin
            m_reg    <= m_next;
            h1_reg   <= hext;
            rad1_reg <= rad_mag;
            p_reg    <= p_next;
            h2_reg   <= h1_reg;
            rsq2_reg <= rsq2_next;
            e_reg    <= e_next;
            rsq3_reg <= rsq2_reg;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            rsq4_reg <= rsq3_reg;
            sq_reg   <= sq_next;
            rsq5_reg <= rsq4_reg;
            sum_reg  <= sum_next;
            rlim_reg <= rlim_next;
            hit_reg  <= hit_next;
        end
    end

    assign result.valid = vld_reg[LAST];
    assign result.hit   = hit_reg;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import sobb_pkg::*;

    localparam int COORD_BITS    = COORD_BITS_DEF;
    localparam int ROT_FRAC_BITS = ROT_FRAC_BITS_DEF;
    localparam int VEC_W         = AXES * COORD_BITS;
    localparam int ONE_ROT       = 1 << ROT_FRAC_BITS;
    localparam int ONE_COORD     = 256;
    localparam int CMAX          = (1 << (COORD_BITS - 1)) - 1;
    localparam int CMIN          = -(1 << (COORD_BITS - 1));
    localparam int RMAX          = 32767;
    localparam int RMIN          = -32768;
    localparam int RAD_MAX       = (1 << (RADIUS_W - 1)) - 1;
    localparam int RAD_MIN       = -(1 << (RADIUS_W - 1));
    localparam int COS_345       = 13107;
    localparam int SIN_345       = 9830;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = BACK_STAGES + QUEUE_DEPTH + 10;
    localparam int RANDOM_HALF   = 800;

    typedef struct packed {
        logic [VEC_W-1:0]           sphere_center;
        logic signed [RADIUS_W-1:0] sphere_radius;
        logic [VEC_W-1:0]           box_center;
        logic [VEC_W-1:0]           box_size;
        logic [ROT_ROW_W-1:0]       rot_row0;
        logic [ROT_ROW_W-1:0]       rot_row1;
        logic [ROT_ROW_W-1:0]       rot_row2;
    } query_word_t;

    logic clk;
    logic rst_n;

    sobb_query_if #(.COORD_BITS(COORD_BITS)) query_ch ();
    sobb_result_if result_ch ();

    sphere_obb_overlap_test #(
        .COORD_BITS    (COORD_BITS),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    query_word_t pending_queries[$];
    bit          expected_hits[$];
    int          mismatch_count = 0;
    int          result_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          ready_cycle = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact integer version of the overlap test: the offset is rotated into
    // the box frame at Q.(8+ROT_FRAC_BITS), so no rounding occurs.
    function automatic bit predict_hit(query_word_t w);
        longint                         offset [AXES];
        logic [ROT_ROW_W-1:0]           rows [AXES];
        longint                         dot;
        longint                         half;
        longint                         mag;
        longint                         excess;
        logic signed [COORD_BITS-1:0]   cs;
        logic signed [COORD_BITS-1:0]   cb;
        logic signed [COORD_BITS-1:0]   ch;
        logic signed [ROT_ENTRY_W-1:0]  entry;
        logic [127:0]                   excess_wide;
        logic [127:0]                   dist_sq;
        logic [127:0]                   rad_wide;
        if (w.sphere_radius[RADIUS_W-1])
            return 1'b0;
        rows[0] = w.rot_row0;
        rows[1] = w.rot_row1;
        rows[2] = w.rot_row2;
        for (int i = 0; i < AXES; i++)
        begin
            cs = w.sphere_center[i*COORD_BITS +: COORD_BITS];
            cb = w.box_center[i*COORD_BITS +: COORD_BITS];
            offset[i] = longint'(cs) - longint'(cb);
        end
        dist_sq = '0;
        for (int j = 0; j < AXES; j++)
        begin
            dot = 0;
            for (int i = 0; i < AXES; i++)
            begin
                entry = rows[j][i*ROT_ENTRY_W +: ROT_ENTRY_W];
                dot += offset[i] * longint'(entry);
            end
            ch = w.box_size[j*COORD_BITS +: COORD_BITS];
            half = (ch < 0) ? 64'sd0 : longint'(ch);
            // Half of the full extent, rescaled to the rotated offset's scale.
            half = half <<< (ROT_FRAC_BITS - 1);
            mag = (dot < 0) ? -dot : dot;
            excess = (mag > half) ? mag - half : 64'sd0;
            excess_wide = 128'(excess);
            dist_sq += excess_wide * excess_wide;
        end
        rad_wide = 128'(longint'(w.sphere_radius)) << ROT_FRAC_BITS;
        return dist_sq <= rad_wide * rad_wide;
    endfunction

    function automatic logic [VEC_W-1:0] pack_coords(int x, int y, int z);
        return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
    endfunction

    function automatic logic [ROT_ROW_W-1:0] pack_row(int c0, int c1, int c2);
        return {c2[ROT_ENTRY_W-1:0], c1[ROT_ENTRY_W-1:0], c0[ROT_ENTRY_W-1:0]};
    endfunction

    function automatic int rand_signed(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_query(logic [VEC_W-1:0] sc, int rad, logic [VEC_W-1:0] bc,
                             logic [VEC_W-1:0] bs, logic [ROT_ROW_W-1:0] r0,
                             logic [ROT_ROW_W-1:0] r1, logic [ROT_ROW_W-1:0] r2);
        query_word_t w;
        w.sphere_center = sc;
        w.sphere_radius = rad[RADIUS_W-1:0];
        w.box_center    = bc;
        w.box_size      = bs;
        w.rot_row0      = r0;
        w.rot_row1      = r1;
        w.rot_row2      = r2;
        pending_queries.insert(pending_queries.size(), w);
    endtask

    task automatic add_directed_queries();
        logic [ROT_ROW_W-1:0] id0;
        logic [ROT_ROW_W-1:0] id1;
        logic [ROT_ROW_W-1:0] id2;
        logic [VEC_W-1:0]     origin;
        logic [VEC_W-1:0]     ones;
        id0 = pack_row(ONE_ROT, 0, 0);
        id1 = pack_row(0, ONE_ROT, 0);
        id2 = pack_row(0, 0, ONE_ROT);
        origin = pack_coords(0, 0, 0);
        ones = '1;
        // Degenerate point sphere at the center of a point box.
        add_query(origin, 0, origin, origin, id0, id1, id2);
        // Negative radius never hits, even when fully overlapping.
        add_query(origin, -1, origin, pack_coords(512, 512, 512), id0, id1, id2);
        add_query(origin, RAD_MIN, origin, pack_coords(CMAX, CMAX, CMAX), id0, id1, id2);
        // Largest radius against the farthest possible centers.
        add_query(pack_coords(CMAX, CMAX, CMAX), RAD_MAX, pack_coords(CMIN, CMIN, CMIN),
                  origin, id0, id1, id2);
        add_query(pack_coords(CMIN, CMIN, CMIN), RAD_MAX, pack_coords(CMAX, CMAX, CMAX),
                  pack_coords(CMAX, CMAX, CMAX), pack_row(RMIN, RMIN, RMIN),
                  pack_row(RMIN, RMIN, RMIN), pack_row(RMIN, RMIN, RMIN));
        // Zero radius exactly on the box surface, then one LSB outside it.
        add_query(pack_coords(ONE_COORD, 0, 0), 0, origin,
                  pack_coords(512, 512, 512), id0, id1, id2);
        add_query(pack_coords(ONE_COORD + 1, 0, 0), 0, origin,
                  pack_coords(512, 512, 512), id0, id1, id2);
        // A negative extent flattens the box on that axis.
        add_query(pack_coords(128, 0, 0), 0, origin, pack_coords(-512, 512, 512),
                  id0, id1, id2);
        add_query(pack_coords(128, 0, 0), 128, origin, pack_coords(-512, 512, 512),
                  id0, id1, id2);
        // Rotations that are not orthonormal are used as given.
        add_query(pack_coords(1000, -2000, 300), 5000, pack_coords(-40, 70, 9),
                  pack_coords(800, 800, 800), pack_row(RMAX, RMAX, RMAX),
                  pack_row(RMAX, RMAX, RMAX), pack_row(RMAX, RMAX, RMAX));
        add_query(pack_coords(CMAX, CMIN, CMAX), 0, origin, origin,
                  pack_row(0, 0, 0), pack_row(0, 0, 0), pack_row(0, 0, 0));
        // Quarter turn about z: a long local x axis lies along world y.
        add_query(pack_coords(0, 512, 0), 0, origin, pack_coords(1024, 256, 256),
                  pack_row(0, ONE_ROT, 0), pack_row(-ONE_ROT, 0, 0), id2);
        add_query(pack_coords(512, 0, 0), 0, origin, pack_coords(1024, 256, 256),
                  pack_row(0, ONE_ROT, 0), pack_row(-ONE_ROT, 0, 0), id2);
        add_query(pack_coords(512, 0, 0), 384, origin, pack_coords(1024, 256, 256),
                  pack_row(0, ONE_ROT, 0), pack_row(-ONE_ROT, 0, 0), id2);
        // Every bit set in every field, with and without a negative radius.
        add_query(ones, -1, ones, ones, '1, '1, '1);
        add_query(ones, RAD_MAX, ones, ones, '1, '1, '1);
        // Sphere touching a point box at distance 5, then just short of it.
        add_query(pack_coords(768, 1024, 0), 1280, origin, origin, id0, id1, id2);
        add_query(pack_coords(768, 1024, 0), 1279, origin, origin, id0, id1, id2);
        add_query(pack_coords(CMAX, CMAX, CMAX), 1, pack_coords(CMAX, CMAX, CMAX),
                  pack_coords(CMAX, CMAX, CMAX), id0, id1, id2);
    endtask

    task automatic add_random_query();
        query_word_t w;
        int          m [AXES][AXES];
        int          perm [AXES];
        int          bc [AXES];
        int          sc [AXES];
        int          sz [AXES];
        int          span;
        int          k;
        int          t;
        int          axis;
        int          p;
        int          q;
        int          s;
        int          rad;
        bit [63:0]   raw;
        if ($urandom_range(0, 4) == 0)
        begin
            raw = {$urandom, $urandom};
            w.sphere_center = raw[VEC_W-1:0];
            raw = {$urandom, $urandom};
            w.box_center = raw[VEC_W-1:0];
            raw = {$urandom, $urandom};
            w.box_size = raw[VEC_W-1:0];
            raw = {$urandom, $urandom};
            w.sphere_radius = raw[RADIUS_W-1:0];
            w.rot_row0 = raw[63:64-ROT_ROW_W];
            raw = {$urandom, $urandom};
            w.rot_row1 = raw[ROT_ROW_W-1:0];
            raw = {$urandom, $urandom};
            w.rot_row2 = raw[ROT_ROW_W-1:0];
            pending_queries.insert(pending_queries.size(), w);
            return;
        end
        case ($urandom_range(0, 3))
            0: span = 64;
            1: span = 1024;
            2: span = 16384;
            default: span = 262144;
        endcase
        for (int j = 0; j < AXES; j++)
        begin
            for (int i = 0; i < AXES; i++)
                m[j][i] = 0;
            perm[j] = j;
        end
        case ($urandom_range(0, 3))
            0:
            begin
                for (int i = AXES - 1; i > 0; i--)
                begin
                    k = $urandom_range(0, i);
                    t = perm[i];
                    perm[i] = perm[k];
                    perm[k] = t;
                end
                for (int j = 0; j < AXES; j++)
                    m[j][perm[j]] = $urandom_range(0, 1) ? ONE_ROT : -ONE_ROT;
            end
            1:
            begin
                axis = $urandom_range(0, AXES - 1);
                p = (axis + 1) % AXES;
                q = (axis + 2) % AXES;
                s = $urandom_range(0, 1) ? SIN_345 : -SIN_345;
                m[axis][axis] = ONE_ROT;
                m[p][p] = COS_345;
                m[p][q] = s;
                m[q][p] = -s;
                m[q][q] = COS_345;
            end
            2:
            begin
                for (int j = 0; j < AXES; j++)
                    m[j][j] = ONE_ROT;
            end
            default:
            begin
                for (int j = 0; j < AXES; j++)
                    for (int i = 0; i < AXES; i++)
                        m[j][i] = int'($urandom_range(0, 65535)) + RMIN;
            end
        endcase
        for (int i = 0; i < AXES; i++)
        begin
            bc[i] = rand_signed(1 << 19);
            sc[i] = bc[i] + rand_signed(2 * span);
            if ($urandom_range(0, 15) == 0)
                sz[i] = -int'($urandom_range(1, span));
            else
                sz[i] = $urandom_range(0, 2 * span);
        end
        if ($urandom_range(0, 15) == 0)
            rad = -int'($urandom_range(1, 1 << (RADIUS_W - 1)));
        else
            rad = $urandom_range(0, span);
        add_query(pack_coords(sc[0], sc[1], sc[2]), rad, pack_coords(bc[0], bc[1], bc[2]),
                  pack_coords(sz[0], sz[1], sz[2]), pack_row(m[0][0], m[0][1], m[0][2]),
                  pack_row(m[1][0], m[1][1], m[1][2]), pack_row(m[2][0], m[2][1], m[2][2]));
    endtask

    task automatic wait_drained();
        while (pending_queries.size() != 0 || expected_hits.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what);
        $display("%0t: result %0d: %s", $time, result_count, what);
        mismatch_count++;
    endtask

    // Query sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (query_ch.valid && query_ch.ready)
                pending_queries.delete(0);
            if (!(query_ch.valid && !query_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    query_ch.valid <= 1'b0;
                end
                else if (pending_queries.size() == 0)
                    query_ch.valid <= 1'b0;
                else
                begin
                    query_ch.valid         <= 1'b1;
                    query_ch.sphere_center <= pending_queries[0].sphere_center;
                    query_ch.sphere_radius <= pending_queries[0].sphere_radius;
                    query_ch.box_center    <= pending_queries[0].box_center;
                    query_ch.box_size      <= pending_queries[0].box_size;
                    query_ch.rot_row0      <= pending_queries[0].rot_row0;
                    query_ch.rot_row1      <= pending_queries[0].rot_row1;
                    query_ch.rot_row2      <= pending_queries[0].rot_row2;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                        if ($urandom_range(0, 9) < 4)
                            gap_left = 0;
                        else if ($urandom_range(0, 9) == 0)
                            gap_left = $urandom_range(5, 20);
                        else
                            gap_left = $urandom_range(1, 3);
                    end
                end
            end
        end
    end

    // Result receiver: cycles through free flow, random stalls, a short
    // periodic stall and long stalls that back up the internal queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_cycle = 0;
        end
        else
        begin
            ready_cycle++;
            case ((ready_cycle >> 8) % 4)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                2: result_ch.ready <= ((ready_cycle % 7) < 3);
                default: result_ch.ready <= ((ready_cycle % 40) >= 15);
            endcase
        end
    end

    always @(posedge clk)
    begin : watch_channels
        query_word_t taken;
        bit          want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch($sformatf("hit=%0b with no query outstanding",
                                              result_ch.hit));
                else
                begin
                    want = expected_hits.pop_front();
                    if (result_ch.hit !== want)
                        report_mismatch($sformatf("hit=%0b, predicted %0b",
                                                  result_ch.hit, want));
                end
                result_count++;
            end
            if (query_ch.valid && query_ch.ready)
            begin
                taken.sphere_center = query_ch.sphere_center;
                taken.sphere_radius = query_ch.sphere_radius;
                taken.box_center    = query_ch.box_center;
                taken.box_size      = query_ch.box_size;
                taken.rot_row0      = query_ch.rot_row0;
                taken.rot_row1      = query_ch.rot_row1;
                taken.rot_row2      = query_ch.rot_row2;
                expected_hits.insert(expected_hits.size(), predict_hit(taken));
            end
            if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        query_ch.valid = 1'b0;
        query_ch.sphere_center = '0;
        query_ch.sphere_radius = '0;
        query_ch.box_center = '0;
        query_ch.box_size = '0;
        query_ch.rot_row0 = '0;
        query_ch.rot_row1 = '0;
        query_ch.rot_row2 = '0;
        result_ch.ready = 1'b0;
        add_directed_queries();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // The sender runs dry between phases so the block drains completely.
        wait_drained();
        for (int n = 0; n < RANDOM_HALF; n++)
            add_random_query();
        wait_drained();
        for (int n = 0; n < RANDOM_HALF; n++)
            add_random_query();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/sobb_pkg.sv
rtl/sobb_ifs.sv
rtl/sobb_front.sv
rtl/sobb_queue.sv
rtl/sobb_back.sv
rtl/sphere_obb_overlap_test.sv
bench/tb_top.sv
